@@ rtl/core/lskt_pkg.sv @@
package lskt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    FN_FIND   = 2'd0,
    FN_INSERT = 2'd1,
    FN_DELETE = 2'd2,
    FN_NONE   = 2'd3
  } lskt_func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_RECORD = 2'd1,
    STS_EXISTS    = 2'd2,
    STS_FULL      = 2'd3
  } lskt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } lskt_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
  } lskt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [4:0]  entry_count;
  } lskt_out_t;

  typedef struct packed {
    logic cmp_en;
    logic del_en;
    logic ins_en;
  } lskt_cell_ctrl_t;

endpackage

@@ rtl/core/lskt_cell.sv @@
module lskt_cell import lskt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lskt_cell_ctrl_t     ctrl,
  input  logic                occupied,
  input  logic                ins_here,
  input  logic [KEY_BITS-1:0] cmp_key,
  input  logic [31:0]         ins_val,
  input  logic [KEY_BITS-1:0] nb_key,
  input  logic [31:0]         nb_val,
  input  logic                hit_in,
  input  logic [31:0]         found_in,
  output logic [KEY_BITS-1:0] key_o,
  output logic [31:0]         val_o,
  output logic                hit_out,
  output logic [31:0]         found_out
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [31:0]         val_r, val_nxt;
  logic                hit_r, hit_nxt;

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    hit_nxt = hit_r;
    if (ctrl.cmp_en) begin
      hit_nxt = occupied && (key_r == cmp_key);
    end
    if (ctrl.ins_en && ins_here) begin
      key_nxt = cmp_key;
      val_nxt = ins_val;
    end else if (ctrl.del_en && (hit_in || hit_r)) begin
      // at or past the deleted entry: pull the upper neighbor down
      key_nxt = nb_key;
      val_nxt = nb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign key_o     = key_r;
  assign val_o     = val_r;
  assign hit_out   = hit_in || hit_r;
  assign found_out = found_in | ((hit_r && !hit_in) ? val_r : 32'd0);

endmodule

@@ rtl/core/linear_scan_key_table_core.sv @@
// Key/value table of CAPACITY entries kept packed in insertion order in a row
// of cells. Each item is find, insert, delete or the unused code (status no
// record) and returns one result with status, found value and entry count.
// An item runs in two steps: a compare state in which every cell compares its
// key, then an execute state in which the hit chain runs along the row, the
// result is registered and an insert or a delete-with-shift is applied. A new
// item is accepted while idle, or in the execute state as the current one
// completes. A stalled result holds off completion of the item behind it.
module linear_scan_key_table_core import lskt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lskt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lskt_out_t out_data
);

  lskt_state_t     state_r, state_nxt;
  lskt_in_t        req_r, req_nxt;
  lskt_out_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  lskt_cell_ctrl_t ctrl;

  logic [CAPACITY:0]   hit_chain;
  logic [31:0]         found_chain [CAPACITY+1];
  logic [KEY_BITS-1:0] key_chain   [CAPACITY+1];
  logic [31:0]         val_chain   [CAPACITY+1];
  logic [CAPACITY-1:0] occupied, ins_here;

  logic any_hit, full, can_finish, in_acc;

  assign hit_chain[0]          = 1'b0;
  assign found_chain[0]        = 32'd0;
  assign key_chain[CAPACITY]   = '0;
  assign val_chain[CAPACITY]   = 32'd0;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occupied[i] = CNT_W'(i) < count_r;
      ins_here[i] = CNT_W'(i) == count_r;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lskt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .occupied  (occupied[g]),
      .ins_here  (ins_here[g]),
      .cmp_key   (req_r.key[KEY_BITS-1:0]),
      .ins_val   (req_r.value),
      .nb_key    (key_chain[g+1]),
      .nb_val    (val_chain[g+1]),
      .hit_in    (hit_chain[g]),
      .found_in  (found_chain[g]),
      .key_o     (key_chain[g]),
      .val_o     (val_chain[g]),
      .hit_out   (hit_chain[g+1]),
      .found_out (found_chain[g+1])
    );
  end

  assign any_hit    = hit_chain[CAPACITY];
  assign full       = count_r == CNT_W'(CAPACITY);
  assign can_finish = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) || ((state_r == S_EXEC) && can_finish);
  assign in_acc     = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_nxt       = out_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctrl          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (can_finish) begin
          out_valid_nxt       = 1'b1;
          out_nxt.found_value = 32'd0;
          out_nxt.status      = STS_NO_RECORD;
          unique case (lskt_func_t'(req_r.func))
            FN_FIND: begin
              if (any_hit) begin
                out_nxt.status      = STS_OK;
                out_nxt.found_value = found_chain[CAPACITY];
              end
            end
            FN_INSERT: begin
              if (any_hit) begin
                out_nxt.status = STS_EXISTS;
              end else if (full) begin
                out_nxt.status = STS_FULL;
              end else begin
                out_nxt.status = STS_OK;
                ctrl.ins_en    = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            FN_DELETE: begin
              if (any_hit) begin
                out_nxt.status = STS_OK;
                ctrl.del_en    = 1'b1;
                count_nxt      = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          out_nxt.entry_count = 5'(count_nxt);
          state_nxt = in_acc ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (in_acc) begin
      req_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sim/linear_scan_key_table_core_tb.sv @@
module linear_scan_key_table_core_tb import lskt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_ITEMS  = 200;
  localparam int POOL_SIZE    = 24;

  // Shadow copy of the table: predicts one result per accepted item and
  // holds the results still owed by the block.
  class lskt_table_scoreboard;
    logic [31:0] keys [CAPACITY];
    logic [31:0] vals [CAPACITY];
    int unsigned fill;
    lskt_out_t   owed_q [$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
      foreach (keys[i]) begin
        keys[i] = '0;
        vals[i] = '0;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_item(lskt_in_t item);
      logic [31:0] kmask;
      logic [31:0] k;
      int unsigned pos;
      lskt_out_t   res;
      kmask = (KEY_BITS >= 32) ? '1 : ((32'd1 << KEY_BITS) - 32'd1);
      k     = item.key & kmask;
      pos   = fill;
      for (int i = 0; i < fill; i++) begin
        if (keys[i] == k) begin
          pos = i;
          break;
        end
      end
      res.status      = STS_NO_RECORD;
      res.found_value = '0;
      case (lskt_func_t'(item.func))
        FN_FIND: begin
          if (pos < fill) begin
            res.status      = STS_OK;
            res.found_value = vals[pos];
          end
        end
        FN_INSERT: begin
          // key check wins over the full check
          if (pos < fill) res.status = STS_EXISTS;
          else if (fill >= CAPACITY) res.status = STS_FULL;
          else begin
            keys[fill] = k;
            vals[fill] = item.value;
            fill++;
            res.status = STS_OK;
          end
        end
        FN_DELETE: begin
          if (pos < fill) begin
            for (int i = pos; i + 1 < fill; i++) begin
              keys[i] = keys[i + 1];
              vals[i] = vals[i + 1];
            end
            keys[fill - 1] = '0;
            vals[fill - 1] = '0;
            fill--;
            res.status = STS_OK;
          end
        end
        default: ;
      endcase
      res.entry_count = fill[4:0];
      owed_q.push_back(res);
    endfunction

    function void check_result(lskt_out_t got);
      lskt_out_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed: status %0d value %h count %0d",
                 $time, got.status, got.found_value, got.entry_count);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.found_value !== want.found_value) begin
        $display("%0t: found_value mismatch: expected %h actual %h",
                 $time, want.found_value, got.found_value);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                 $time, want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  lskt_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lskt_out_t out_data;

  bit          final_stretch = 1'b0;
  logic [31:0] key_pool [POOL_SIZE];
  lskt_table_scoreboard board = new();

  linear_scan_key_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAIL linear_scan_key_table_core");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // result side: random stall bursts, calm stretches, none at the end
  initial begin
    int  stall;
    int  cyc;
    bit  calm;
    stall = 0;
    cyc   = 0;
    calm  = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 97 == 0) calm = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!final_stretch && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called right after a rising edge; holds valid until the item is taken
  task automatic send_item(input lskt_in_t item, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(item);
  endtask

  task automatic send_op(input lskt_func_t f, input logic [31:0] k, input logic [31:0] v);
    lskt_in_t item;
    item.func  = f;
    item.key   = k;
    item.value = v;
    send_item(item, 0);
  endtask

  task automatic wait_all_results();
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] dkeys [CAPACITY];
    lskt_in_t    item;
    int          mode;
    int          r;
    int          gap;
    bit          calm_tx;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < CAPACITY; i++) begin
      dkeys[i] = 32'hA5A5_0000 ^ i;
    end
    dkeys[0]            = 32'h0000_0000;
    dkeys[CAPACITY - 1] = 32'hFFFF_FFFF;

    // directed: empty table, unused code, fill up, full and duplicate,
    // delete from the middle, the end and the front
    send_op(FN_FIND, 32'hFFFF_FFFF, 32'h0);
    send_op(FN_NONE, 32'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < CAPACITY; i++) begin
      send_op(FN_INSERT, dkeys[i], (i == 0) ? 32'h0 :
              (i == CAPACITY - 1) ? 32'hFFFF_FFFF : $urandom);
    end
    send_op(FN_INSERT, 32'h1234_5678, $urandom);
    send_op(FN_INSERT, dkeys[7], $urandom);
    send_op(FN_FIND, dkeys[CAPACITY - 1], 32'h0);
    send_op(FN_DELETE, dkeys[7], $urandom);
    send_op(FN_FIND, dkeys[7], 32'h0);
    send_op(FN_DELETE, dkeys[7], 32'h0);
    send_op(FN_DELETE, dkeys[CAPACITY - 1], 32'h0);
    send_op(FN_DELETE, dkeys[0], 32'h0);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_all_results();

    // small key pool so that hits, duplicates and a full table are common
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;

    mode    = 0;
    calm_tx = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) begin
        mode    = $urandom_range(0, 2);
        calm_tx = ($urandom_range(0, 3) == 0);
        key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) final_stretch = 1'b1;
      if (n > 0 && n % 400 == 0 && !final_stretch) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_all_results();
      end

      r = $urandom_range(0, 99);
      case (mode)
        0: item.func = (r < 60) ? FN_INSERT : (r < 80) ? FN_FIND :
                       (r < 97) ? FN_DELETE : FN_NONE;
        1: item.func = (r < 20) ? FN_INSERT : (r < 45) ? FN_FIND :
                       (r < 95) ? FN_DELETE : FN_NONE;
        default: item.func = (r < 35) ? FN_INSERT : (r < 65) ? FN_FIND :
                             (r < 95) ? FN_DELETE : FN_NONE;
      endcase
      item.key = ($urandom_range(0, 9) == 0) ? $urandom
                                             : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      r = $urandom_range(0, 19);
      item.value = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;

      gap = 0;
      if (!final_stretch && !calm_tx && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
      send_item(item, gap);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_all_results();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS linear_scan_key_table_core");
    end else begin
      $display("FAIL linear_scan_key_table_core");
    end
    $finish;
  end

endmodule

@@ linear_scan_key_table_core.f @@
rtl/core/lskt_pkg.sv
rtl/core/lskt_cell.sv
rtl/core/linear_scan_key_table_core.sv
sim/linear_scan_key_table_core_tb.sv
